// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== sv/fram_pkg.sv =====
// opcode and sequencer state types for the four register alu machine
package fram_pkg;

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_OUT  = 3'd1,
		OP_MOV  = 3'd2,
		OP_ADD  = 3'd3,
		OP_SUB  = 3'd4,
		OP_MUL  = 3'd5,
		OP_DIV  = 3'd6
	} op_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SER  = 6'b000010,
		S_MUL  = 6'b000100,
		S_DIV  = 6'b001000,
		S_FIX  = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	localparam int unsigned IO_WIDTH = 64;

endpackage

// ===== sv/four_register_alu_machine.sv =====
// four register alu machine with bit-serial add/sub, shift-add multiply and restoring divide
// load, move and same-register cases finish straight from idle; add, subtract and multiply
// step one bit per cycle through S_SER or S_MUL; divide steps through S_DIV, then S_FIX for the sign
// output and divide-by-zero pass through S_EMIT to load the output register, waiting there
// while an earlier result is still held; one request at a time, the serial step counter sets the rate
// reset clears the four registers to zero and empties the output register
`include "assert_macros.svh"

module four_register_alu_machine
	import fram_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 op,
	input  logic [1:0]                 dest,
	input  logic [1:0]                 src,
	input  logic signed [IO_WIDTH-1:0] imm,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [IO_WIDTH-1:0] value,
	output logic                       div_by_zero
);

	localparam int unsigned CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [DATA_WIDTH-1:0]   regs_q [4];
	logic                    out_valid_q;

	logic [DATA_WIDTH-1:0]   x_q;
	logic [DATA_WIDTH-1:0]   y_q;
	logic [DATA_WIDTH-1:0]   acc_q;
	logic                    carry_q;
	logic                    neg_q;
	logic                    err_q;
	logic [1:0]              dest_q;
	logic [IO_WIDTH-1:0]     value_q;
	logic                    div_by_zero_q;

	logic                    accept;
	logic                    same;
	logic                    last;
	logic                    emit_load;
	logic [DATA_WIDTH-1:0]   rd_x;
	logic [DATA_WIDTH-1:0]   rd_y;
	logic [DATA_WIDTH-1:0]   abs_x;
	logic [DATA_WIDTH-1:0]   abs_y;
	logic                    sbit;
	logic                    cnext;
	logic [DATA_WIDTH-1:0]   ser_res;
	logic [DATA_WIDTH-1:0]   mul_sum;
	logic [DATA_WIDTH:0]     trial;
	logic                    qbit;
	logic [DATA_WIDTH-1:0]   rem_next;
	logic [DATA_WIDTH-1:0]   quot_fix;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign rd_x        = regs_q[dest];
	assign rd_y        = regs_q[src];
	assign same        = (dest == src);
	assign last        = (cnt_q == CW'(DATA_WIDTH - 1));
	assign emit_load   = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	assign abs_x       = rd_x[DATA_WIDTH-1] ? (~rd_x + 1'b1) : rd_x;
	assign abs_y       = rd_y[DATA_WIDTH-1] ? (~rd_y + 1'b1) : rd_y;

	// serial adder, one bit per cycle
	assign sbit        = x_q[0] ^ y_q[0] ^ carry_q;
	assign cnext       = (x_q[0] & y_q[0]) | (carry_q & (x_q[0] ^ y_q[0]));
	assign ser_res     = {sbit, acc_q[DATA_WIDTH-1:1]};

	// shift-add multiply step
	assign mul_sum     = acc_q + (y_q[0] ? x_q : '0);

	// restoring divide step
	assign trial       = {acc_q, x_q[DATA_WIDTH-1]} - {1'b0, y_q};
	assign qbit        = !trial[DATA_WIDTH];
	assign rem_next    = qbit ? trial[DATA_WIDTH-1:0] : {acc_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};
	assign quot_fix    = neg_q ? (~x_q + 1'b1) : x_q;

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign div_by_zero = div_by_zero_q;

	// sequencer, register file and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						unique case (op)
							OP_LOAD: regs_q[dest] <= imm[DATA_WIDTH-1:0];
							OP_OUT:  state_q <= S_EMIT;
							OP_MOV: begin
								if (!same) regs_q[dest] <= rd_y;
							end
							OP_ADD:  state_q <= S_SER;
							OP_SUB: begin
								if (same) regs_q[dest] <= '0;
								else state_q <= S_SER;
							end
							OP_MUL:  state_q <= S_MUL;
							OP_DIV: begin
								if (same) regs_q[dest] <= DATA_WIDTH'(1);
								else if (rd_y == '0) state_q <= S_EMIT;
								else state_q <= S_DIV;
							end
							default: ;
						endcase
					end
				end
				S_SER: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						regs_q[dest_q] <= ser_res;
						state_q        <= S_IDLE;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						regs_q[dest_q] <= mul_sum;
						state_q        <= S_IDLE;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) state_q <= S_FIX;
				end
				S_FIX: begin
					regs_q[dest_q] <= quot_fix;
					state_q        <= S_IDLE;
				end
				S_EMIT: begin
					if (emit_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			dest_q  <= dest;
			acc_q   <= '0;
			neg_q   <= rd_x[DATA_WIDTH-1] ^ rd_y[DATA_WIDTH-1];
			unique case (op)
				OP_SUB: begin
					x_q     <= rd_x;
					y_q     <= ~rd_y;
					carry_q <= 1'b1;
					err_q   <= 1'b0;
				end
				OP_DIV: begin
					x_q     <= (rd_y == '0) ? '0 : abs_x;
					y_q     <= abs_y;
					carry_q <= 1'b0;
					err_q   <= (rd_y == '0);
				end
				default: begin
					x_q     <= rd_x;
					y_q     <= rd_y;
					carry_q <= 1'b0;
					err_q   <= 1'b0;
				end
			endcase
		end else begin
			unique case (state_q)
				S_SER: begin
					x_q     <= x_q >> 1;
					y_q     <= y_q >> 1;
					acc_q   <= ser_res;
					carry_q <= cnext;
				end
				S_MUL: begin
					x_q   <= x_q << 1;
					y_q   <= y_q >> 1;
					acc_q <= mul_sum;
				end
				S_DIV: begin
					x_q   <= {x_q[DATA_WIDTH-2:0], qbit};
					acc_q <= rem_next;
				end
				default: ;
			endcase
		end
		if (emit_load) begin
			value_q       <= IO_WIDTH'($signed(x_q));
			div_by_zero_q <= err_q;
		end
	end

	`ASSERT_IMPL(a_err_value_zero, clk, arst_n, (out_valid && div_by_zero) |-> (value == '0))
	`ASSERT_IMPL(a_out_goes_emit, clk, arst_n, (accept && op == OP_OUT) |=> (state_q == S_EMIT))
	`ASSERT_IMPL(a_rem_below_div, clk, arst_n, (state_q == S_DIV) |-> (acc_q < y_q))
	`ASSERT_IMPL(a_valid_from_emit, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_EMIT))

endmodule
